// File: hw/rtl/pfdc_pkg.sv
// shared types, constants and helpers of the depth controller
`timescale 1ns / 1ps
`default_nettype none

package pfdc_pkg;

    localparam int DATA_W = 32;
    localparam int FRAC_W = 16;
    localparam int TS_W   = 17;
    localparam int OPND_W = DATA_W + 1;
    localparam int PROD_W = 2 * OPND_W;
    localparam int DIV_W  = OPND_W + FRAC_W;
    localparam int ACC_W  = DATA_W + 4;
    localparam int CNT_W  = $clog2(DIV_W + 1);

    localparam logic [TS_W-1:0] TS_MIN = 17'd3277;
    localparam logic [TS_W-1:0] TS_MAX = 17'd13107;

    localparam logic signed [DATA_W-1:0] DMAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic signed [DATA_W-1:0] DMIN = {1'b1, {(DATA_W-1){1'b0}}};

    // register indexes on the config port
    localparam logic [2:0] REG_PI     = 3'd0;
    localparam logic [2:0] REG_DB     = 3'd1;
    localparam logic [2:0] REG_FF     = 3'd2;
    localparam logic [2:0] REG_DRAG   = 3'd3;
    localparam logic [2:0] REG_ELIM   = 3'd4;
    localparam logic [2:0] REG_OLIM   = 3'd5;
    localparam logic [2:0] REG_ENABLE = 3'd6;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_DIV_REF,
        ST_DIV_ERR,
        ST_MUL,
        ST_MUL_WB,
        ST_DONE
    } pfdc_state_t;

    typedef enum logic [3:0] {
        OP_SCALE,
        OP_DRAG,
        OP_FFQ1,
        OP_FFQ2,
        OP_FFR,
        OP_DRAGCUR,
        OP_P,
        OP_I,
        OP_D
    } pfdc_op_t;

    typedef struct packed {
        logic             start;
        logic [OPND_W-1:0] dividend;
        logic [TS_W-1:0]   divisor;
    } pfdc_div_req_t;

    function automatic logic signed [DATA_W-1:0] sat_opnd(input logic signed [OPND_W-1:0] v);
        logic signed [DATA_W-1:0] r;
        if (v[OPND_W-1] != v[OPND_W-2])
            r = v[OPND_W-1] ? DMIN : DMAX;
        else
            r = v[DATA_W-1:0];
        return r;
    endfunction

    function automatic logic signed [OPND_W-1:0] mag_opnd(input logic signed [DATA_W-1:0] v);
        logic signed [OPND_W-1:0] x;
        x = {v[DATA_W-1], v};
        return v[DATA_W-1] ? -x : x;
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/pfdc_mul.sv
// shared signed multiplier with floored fixed-point scaling and saturation
`timescale 1ns / 1ps
`default_nettype none

module pfdc_mul
(
    input  wire logic                                 clk,
    input  wire logic signed [pfdc_pkg::OPND_W-1:0]   a,
    input  wire logic signed [pfdc_pkg::OPND_W-1:0]   b,
    output logic signed [pfdc_pkg::DATA_W-1:0]        res
);

    localparam int SH_W = pfdc_pkg::PROD_W - pfdc_pkg::FRAC_W;

    logic signed [pfdc_pkg::PROD_W-1:0] prod_reg;
    logic signed [SH_W-1:0]             shifted;

    always_ff @(posedge clk)
    begin
        prod_reg <= a * b;
    end

    // arithmetic shift floors toward minus infinity
    always_comb
    begin
        shifted = prod_reg[pfdc_pkg::PROD_W-1:pfdc_pkg::FRAC_W];
        if (shifted > SH_W'(pfdc_pkg::DMAX))
            res = pfdc_pkg::DMAX;
        else if (shifted < SH_W'(pfdc_pkg::DMIN))
            res = pfdc_pkg::DMIN;
        else
            res = shifted[pfdc_pkg::DATA_W-1:0];
    end

endmodule

`default_nettype wire

// File: hw/rtl/pfdc_div.sv
// bit-serial restoring divider for the rate terms, one quotient bit a cycle
`timescale 1ns / 1ps
`default_nettype none

module pfdc_div
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire pfdc_pkg::pfdc_div_req_t        req,
    output logic                                done,
    output logic [pfdc_pkg::DIV_W-1:0]          quotient
);

    localparam int REM_W = pfdc_pkg::TS_W + 1;

    logic [pfdc_pkg::DIV_W-1:0] num_reg, num_next;
    logic [pfdc_pkg::DIV_W-1:0] quo_reg, quo_next;
    logic [REM_W-1:0]           rem_reg, rem_next;
    logic [pfdc_pkg::TS_W-1:0]  dsr_reg, dsr_next;
    logic [pfdc_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    logic                       done_reg, done_next;
    logic [REM_W-1:0]           trial;

    always_comb
    begin
        num_next  = num_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        trial     = {rem_reg[REM_W-2:0], num_reg[pfdc_pkg::DIV_W-1]};
        if (req.start)
        begin
            num_next = {req.dividend, {pfdc_pkg::FRAC_W{1'b0}}};
            quo_next = '0;
            rem_next = '0;
            dsr_next = req.divisor;
            cnt_next = pfdc_pkg::CNT_W'(pfdc_pkg::DIV_W);
        end
        else if (cnt_reg != '0)
        begin
            num_next = {num_reg[pfdc_pkg::DIV_W-2:0], 1'b0};
            if (trial >= {1'b0, dsr_reg})
            begin
                rem_next = trial - {1'b0, dsr_reg};
                quo_next = {quo_reg[pfdc_pkg::DIV_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial;
                quo_next = {quo_reg[pfdc_pkg::DIV_W-2:0], 1'b0};
            end
            cnt_next  = cnt_reg - 1'b1;
            done_next = (cnt_reg == pfdc_pkg::CNT_W'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

// File: hw/rtl/pid_feedforward_depth_controller.sv
// depth controller top: config registers, step sequencer and datapath state
// a clear or held-off word is answered in the cycle after it is accepted; a control step runs
// a setup step, two rate divisions on the serial divider, nine products through the shared
// multiplier and a sum step
// flow: one word at a time, the next word accepted only after the result is taken
// reset: async active-low clears config, integral and history, output empty
`timescale 1ns / 1ps
`default_nettype none

module pid_feedforward_depth_controller
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [5:0]  paddr,
    input  wire logic [63:0] pwdata,
    output logic [63:0]      prdata,
    output logic             pready,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [87:0] s_tdata,   // error_value, reference, time_step, zero pad
    input  wire logic [0:0]  s_tuser,   // command
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [63:0]      m_tdata,   // drive, integral_value
    output logic [1:0]       m_tuser    // held_off, limited
);

    localparam int DW = pfdc_pkg::DATA_W;
    localparam int OW = pfdc_pkg::OPND_W;
    localparam int TW = pfdc_pkg::TS_W;
    localparam int AW = pfdc_pkg::ACC_W;

    pfdc_pkg::pfdc_state_t state_reg, state_next;
    pfdc_pkg::pfdc_op_t    op_reg, op_next;

    logic [63:0] cfg_reg [0:5];
    logic        enable_reg;

    logic signed [DW-1:0] int_reg, prev_err_reg, prev_ref_reg;
    logic signed [DW-1:0] err_in_reg, ref_reg, err_reg, cur_reg;
    logic [TW-1:0]        ts_reg;
    logic signed [DW-1:0] int_new_reg, drag_reg, m1_reg, refrate_reg, errrate_reg;
    logic signed [AW-1:0] acc_reg;
    logic                 neg_reg;

    logic [63:0] out_data_reg;
    logic [1:0]  out_user_reg;
    logic        out_valid_reg;

    logic cfg_we, accept, held;
    logic signed [DW-1:0] in_err, in_ref;
    logic [TW-1:0]        in_ts;

    pfdc_pkg::pfdc_div_req_t div_req;
    logic                    div_done;
    logic [pfdc_pkg::DIV_W-1:0] div_q;
    logic signed [OW-1:0]    mul_a, mul_b;
    logic signed [DW-1:0]    mul_res;

    logic signed [DW-1:0] e_min, e_max, o_min, o_max, err_clamp, rate_val;
    logic signed [OW-1:0] ref_diff, err_diff;
    logic signed [AW-1:0] sum_full;
    logic signed [DW-1:0] sum_sat;

    assign in_err = s_tdata[31:0];
    assign in_ref = s_tdata[63:32];
    assign in_ts  = s_tdata[80:64];

    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite;
    assign accept = s_tvalid && s_tready;

    assign e_max = cfg_reg[pfdc_pkg::REG_ELIM][63:32];
    assign e_min = cfg_reg[pfdc_pkg::REG_ELIM][31:0];
    assign o_max = cfg_reg[pfdc_pkg::REG_OLIM][63:32];
    assign o_min = cfg_reg[pfdc_pkg::REG_OLIM][31:0];

    assign held = !enable_reg || (in_ts < pfdc_pkg::TS_MIN) || (in_ts > pfdc_pkg::TS_MAX);

    always_comb
    begin
        prdata = '0;
        case (paddr[5:3])
            pfdc_pkg::REG_PI:     prdata = cfg_reg[pfdc_pkg::REG_PI];
            pfdc_pkg::REG_DB:     prdata = cfg_reg[pfdc_pkg::REG_DB];
            pfdc_pkg::REG_FF:     prdata = cfg_reg[pfdc_pkg::REG_FF];
            pfdc_pkg::REG_DRAG:   prdata = cfg_reg[pfdc_pkg::REG_DRAG];
            pfdc_pkg::REG_ELIM:   prdata = cfg_reg[pfdc_pkg::REG_ELIM];
            pfdc_pkg::REG_OLIM:   prdata = cfg_reg[pfdc_pkg::REG_OLIM];
            pfdc_pkg::REG_ENABLE: prdata = {63'd0, enable_reg};
            default:              prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 6; i++)
                cfg_reg[i] <= '0;
            enable_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            if (paddr[5:3] == pfdc_pkg::REG_ENABLE)
                enable_reg <= pwdata[0];
            else if (paddr[5:3] < pfdc_pkg::REG_ENABLE)
                cfg_reg[paddr[5:3]] <= pwdata;
        end
    end

    // error clamp, min tested first
    always_comb
    begin
        if (err_in_reg < e_min)
            err_clamp = e_min;
        else if (err_in_reg > e_max)
            err_clamp = e_max;
        else
            err_clamp = err_in_reg;
    end

    assign ref_diff = OW'(ref_reg) - OW'(prev_ref_reg);
    assign err_diff = OW'(err_reg) - OW'(prev_err_reg);

    // signed, saturated rate from the unsigned quotient
    always_comb
    begin
        logic signed [DW-1:0] q;
        if (div_q > pfdc_pkg::DIV_W'(pfdc_pkg::DMAX))
            q = pfdc_pkg::DMAX;
        else
            q = div_q[DW-1:0];
        rate_val = neg_reg ? -q : q;
    end

    always_comb
    begin
        div_req.start    = 1'b0;
        div_req.dividend = pfdc_pkg::mag_opnd(DW'(0));
        div_req.divisor  = ts_reg;
        case (state_reg)
            pfdc_pkg::ST_PREP:
            begin
                div_req.start    = 1'b1;
                div_req.dividend = ref_diff[OW-1] ? -ref_diff : ref_diff;
            end
            pfdc_pkg::ST_DIV_REF:
            begin
                div_req.start    = div_done;
                div_req.dividend = err_diff[OW-1] ? -err_diff : err_diff;
            end
            default:
            begin
                div_req.start = 1'b0;
            end
        endcase
    end

    pfdc_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (div_req),
        .done     (div_done),
        .quotient (div_q)
    );

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (op_reg)
            pfdc_pkg::OP_SCALE:
            begin
                mul_a = OW'(err_reg);
                mul_b = OW'({1'b0, ts_reg});
            end
            pfdc_pkg::OP_DRAG:
            begin
                mul_a = OW'($signed(cfg_reg[pfdc_pkg::REG_DRAG][31:0]));
                mul_b = pfdc_pkg::mag_opnd(cur_reg);
            end
            pfdc_pkg::OP_FFQ1:
            begin
                mul_a = OW'($signed(cfg_reg[pfdc_pkg::REG_FF][63:32]));
                mul_b = pfdc_pkg::mag_opnd(ref_reg);
            end
            pfdc_pkg::OP_FFQ2:
            begin
                mul_a = OW'(m1_reg);
                mul_b = OW'(ref_reg);
            end
            pfdc_pkg::OP_FFR:
            begin
                mul_a = OW'($signed(cfg_reg[pfdc_pkg::REG_FF][31:0]));
                mul_b = OW'(refrate_reg);
            end
            pfdc_pkg::OP_DRAGCUR:
            begin
                mul_a = OW'(drag_reg);
                mul_b = OW'(cur_reg);
            end
            pfdc_pkg::OP_P:
            begin
                mul_a = OW'($signed(cfg_reg[pfdc_pkg::REG_PI][63:32]));
                mul_b = OW'(err_reg);
            end
            pfdc_pkg::OP_I:
            begin
                mul_a = OW'($signed(cfg_reg[pfdc_pkg::REG_PI][31:0]));
                mul_b = OW'(int_new_reg);
            end
            pfdc_pkg::OP_D:
            begin
                mul_a = OW'($signed(cfg_reg[pfdc_pkg::REG_DB][63:32]));
                mul_b = OW'(errrate_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    pfdc_mul u_mul
    (
        .clk (clk),
        .a   (mul_a),
        .b   (mul_b),
        .res (mul_res)
    );

    assign sum_full = acc_reg - AW'($signed(cfg_reg[pfdc_pkg::REG_DB][31:0]));
    always_comb
    begin
        if (sum_full > AW'(pfdc_pkg::DMAX))
            sum_sat = pfdc_pkg::DMAX;
        else if (sum_full < AW'(pfdc_pkg::DMIN))
            sum_sat = pfdc_pkg::DMIN;
        else
            sum_sat = sum_full[DW-1:0];
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        case (state_reg)
            pfdc_pkg::ST_IDLE:
            begin
                op_next = pfdc_pkg::OP_SCALE;
                if (accept && !s_tuser[0] && !held)
                    state_next = pfdc_pkg::ST_PREP;
            end
            pfdc_pkg::ST_PREP:    state_next = pfdc_pkg::ST_DIV_REF;
            pfdc_pkg::ST_DIV_REF:
            begin
                if (div_done)
                    state_next = pfdc_pkg::ST_DIV_ERR;
            end
            pfdc_pkg::ST_DIV_ERR:
            begin
                if (div_done)
                    state_next = pfdc_pkg::ST_MUL;
            end
            pfdc_pkg::ST_MUL:     state_next = pfdc_pkg::ST_MUL_WB;
            pfdc_pkg::ST_MUL_WB:
            begin
                if (op_reg == pfdc_pkg::OP_D)
                    state_next = pfdc_pkg::ST_DONE;
                else
                begin
                    state_next = pfdc_pkg::ST_MUL;
                    op_next    = pfdc_pkg::pfdc_op_t'(op_reg + 4'd1);
                end
            end
            pfdc_pkg::ST_DONE:    state_next = pfdc_pkg::ST_IDLE;
            default:              state_next = pfdc_pkg::ST_IDLE;
        endcase
    end

    // handshake outputs
    always_comb
    begin
        s_tready = 1'b0;
        case (state_reg)
            pfdc_pkg::ST_IDLE: s_tready = !out_valid_reg;
            default:           s_tready = 1'b0;
        endcase
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= pfdc_pkg::ST_IDLE;
            op_reg        <= pfdc_pkg::OP_SCALE;
            out_valid_reg <= 1'b0;
            int_reg       <= '0;
            prev_err_reg  <= '0;
            prev_ref_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            op_reg    <= op_next;
            if (m_tready)
                out_valid_reg <= 1'b0;
            if (state_reg == pfdc_pkg::ST_IDLE && accept)
            begin
                if (s_tuser[0])
                begin
                    int_reg       <= '0;
                    prev_err_reg  <= '0;
                    prev_ref_reg  <= '0;
                    out_valid_reg <= 1'b1;
                end
                else if (held)
                    out_valid_reg <= 1'b1;
            end
            if (state_reg == pfdc_pkg::ST_DONE)
            begin
                if (sum_sat <= o_max && sum_sat >= o_min)
                    int_reg <= int_new_reg;
                prev_err_reg  <= err_reg;
                prev_ref_reg  <= ref_reg;
                out_valid_reg <= 1'b1;
            end
        end
    end

    // datapath payload
    always_ff @(posedge clk)
    begin
        case (state_reg)
            pfdc_pkg::ST_IDLE:
            begin
                err_in_reg <= in_err;
                ref_reg    <= in_ref;
                ts_reg     <= in_ts;
                if (accept)
                begin
                    out_data_reg <= {s_tuser[0] ? 32'd0 : int_reg, 32'd0};
                    out_user_reg <= {1'b0, !s_tuser[0]};
                end
            end
            pfdc_pkg::ST_PREP:
            begin
                err_reg <= err_clamp;
                cur_reg <= pfdc_pkg::sat_opnd(OW'(ref_reg) - OW'(err_in_reg));
                acc_reg <= '0;
                neg_reg <= ref_diff[OW-1];
            end
            pfdc_pkg::ST_DIV_REF:
            begin
                if (div_done)
                begin
                    refrate_reg <= rate_val;
                    neg_reg     <= err_diff[OW-1];
                end
            end
            pfdc_pkg::ST_DIV_ERR:
            begin
                if (div_done)
                    errrate_reg <= rate_val;
            end
            pfdc_pkg::ST_MUL_WB:
            begin
                case (op_reg)
                    pfdc_pkg::OP_SCALE:
                        int_new_reg <= pfdc_pkg::sat_opnd(OW'(int_reg) + OW'(mul_res));
                    pfdc_pkg::OP_DRAG:
                        drag_reg <= pfdc_pkg::sat_opnd(
                            OW'($signed(cfg_reg[pfdc_pkg::REG_DRAG][63:32])) + OW'(mul_res));
                    pfdc_pkg::OP_FFQ1:
                        m1_reg <= mul_res;
                    default:
                        acc_reg <= acc_reg + AW'(mul_res);
                endcase
            end
            pfdc_pkg::ST_DONE:
            begin
                // output max tested first, then min
                if (sum_sat > o_max)
                begin
                    out_data_reg <= {int_reg, o_max};
                    out_user_reg <= 2'b10;
                end
                else if (sum_sat < o_min)
                begin
                    out_data_reg <= {int_reg, o_min};
                    out_user_reg <= 2'b10;
                end
                else
                begin
                    out_data_reg <= {int_new_reg, sum_sat};
                    out_user_reg <= 2'b00;
                end
            end
            default:
            begin
                acc_reg <= acc_reg;
            end
        endcase
    end

endmodule

`default_nettype wire
